FILE: hw/rtl/oaht_pkg.sv
`timescale 1ns / 1ps
// Package for the open addressing hash table core: sizes, codes and FSM types.
// No dependencies; used by open_addressing_hash_table_core.
package oaht_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int MAX_PROBES  = 1024;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 11;
    localparam int SIZE_W      = 17;
    localparam int MOD_W       = 16;
    localparam int PROD_W      = 27;
    localparam int ENTRY_W     = 1 + LEN_W + KEY_W;

    // Opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Probe modes
    localparam logic [1:0] PM_LINEAR = 2'd0;
    localparam logic [1:0] PM_QUAD   = 2'd1;
    localparam logic [1:0] PM_DOUBLE = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_HASH_SEL = 2'd0;
    localparam logic [1:0] REG_PROBE    = 2'd1;
    localparam logic [1:0] REG_DMOD     = 2'd2;
    localparam logic [1:0] REG_SIZE     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_HASH, S_DIV, S_READ, S_CHECK,
        S_MUL, S_ADD, S_WRITE, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DR_HASH, DR_DMOD, DR_PROBE
    } t_div_ret;

endpackage

FILE: hw/rtl/open_addressing_hash_table_core.sv
`timescale 1ns / 1ps
// Open addressing hash table core: hash, shared divider, probe walk, slot memory.
// Depends on oaht_pkg.
//
// One transaction at a time: i_start is taken when o_busy is low and exactly one
// result follows on o_done, which cannot be stalled. A search or insert hashes
// the key one byte at a time, runs the bit-serial divider for the start slot
// (a second division in double hashing mode), then for every collision does a
// multiply, an add, a modulo by the table size on the divider, a memory read and
// a compare; an insert that writes also passes through a write state. A clear
// sweeps the slot memory one entry per cycle, then gives its result; the same
// sweep runs after reset, with no result and o_busy high. Configuration writes
// are always ready.
module open_addressing_hash_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    output logic        o_done,
    output logic [15:0] o_slot_index,
    output logic [10:0] o_probe_count,
    output logic        o_key_found,
    output logic        o_key_inserted,
    output logic        o_gave_up,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    oaht_pkg::t_state   r_state, n_state;
    oaht_pkg::t_div_ret r_dret;

    logic                              r_hash_sel;
    logic [1:0]                        r_probe_mode;
    logic [oaht_pkg::MOD_W-1:0]        r_dmod;
    logic [oaht_pkg::SIZE_W-1:0]       r_size;

    logic [1:0]                        r_op;
    logic [oaht_pkg::KEY_W-1:0]        r_key;
    logic [oaht_pkg::LEN_W-1:0]        r_len;
    logic [31:0]                       r_v;
    logic [oaht_pkg::LEN_W-1:0]        r_j;
    logic [31:0]                       r_dvd;
    logic [oaht_pkg::SIZE_W-1:0]       r_rem;
    logic [oaht_pkg::SIZE_W-1:0]       r_dvs;
    logic [4:0]                        r_dcnt;
    logic [oaht_pkg::ADDR_W-1:0]       r_x;
    logic [oaht_pkg::MOD_W-1:0]        r_d;
    logic [oaht_pkg::CNT_W-1:0]        r_i;
    logic [oaht_pkg::PROD_W-1:0]       r_prod;
    logic [oaht_pkg::ADDR_W-1:0]       r_cur;
    logic [oaht_pkg::ADDR_W:0]         r_clr;
    logic                              r_clr_rep;
    logic                              r_found, r_gave, r_ins;
    logic [oaht_pkg::ENTRY_W-1:0]      r_rd;

    logic [oaht_pkg::ENTRY_W-1:0]      mem [oaht_pkg::TABLE_DEPTH];

    logic                              accept;
    logic [oaht_pkg::LEN_W-1:0]        len_sat;
    logic [oaht_pkg::KEY_W-1:0]        key_mask;
    logic [oaht_pkg::SIZE_W-1:0]       tam;
    logic [oaht_pkg::MOD_W-1:0]        m_eff;
    logic [31:0]                       sbyte;
    logic [oaht_pkg::SIZE_W-1:0]       div_t, div_rem;
    logic                              div_last;
    logic                              rd_used, rd_eq, at_limit, walk_stop;
    logic [oaht_pkg::MOD_W-1:0]        factor;
    logic                              mem_we;
    logic [oaht_pkg::ADDR_W-1:0]       mem_addr;
    logic [oaht_pkg::ENTRY_W-1:0]      mem_wdata;

    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    // Saturated length and masked key
    always_comb begin
        len_sat  = (i_key_length > oaht_pkg::LEN_W'(oaht_pkg::KEY_BYTES))
                 ? oaht_pkg::LEN_W'(oaht_pkg::KEY_BYTES) : i_key_length;
        key_mask = '0;
        for (int b = 0; b < oaht_pkg::KEY_BYTES; b++) begin
            if (oaht_pkg::LEN_W'(b) < len_sat) begin
                key_mask[8*b +: 8] = i_key_bytes[8*b +: 8];
            end
        end
    end

    // Effective table size and modulus
    always_comb begin
        if (r_size == '0) begin
            tam = oaht_pkg::SIZE_W'(1);
        end else if (r_size > oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH)) begin
            tam = oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH);
        end else begin
            tam = r_size;
        end
        m_eff = (r_dmod == '0) ? oaht_pkg::MOD_W'(1) : r_dmod;
    end

    // Sign-extended key byte for the hash loop
    assign sbyte = {{24{r_key[8*r_j[2:0] + 7]}}, r_key[8*r_j[2:0] +: 8]};

    // One restoring divider step; remainder is always below the divisor
    always_comb begin
        div_t    = {r_rem[oaht_pkg::SIZE_W-2:0], r_dvd[31]};
        div_rem  = (div_t >= r_dvs) ? div_t - r_dvs : div_t;
        div_last = (r_dcnt == '0);
    end

    // Slot compare
    always_comb begin
        rd_used   = r_rd[oaht_pkg::ENTRY_W-1];
        rd_eq     = (r_rd[oaht_pkg::ENTRY_W-2 -: oaht_pkg::LEN_W] == r_len)
                 && (r_rd[oaht_pkg::KEY_W-1:0] == r_key);
        at_limit  = (r_i >= oaht_pkg::CNT_W'(oaht_pkg::MAX_PROBES));
        walk_stop = !rd_used || rd_eq || at_limit;
        case (r_probe_mode)
            oaht_pkg::PM_QUAD:   factor = oaht_pkg::MOD_W'(r_i);
            oaht_pkg::PM_DOUBLE: factor = r_d;
            default:             factor = oaht_pkg::MOD_W'(1);
        endcase
    end

    // Memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_cur;
        mem_wdata = {1'b1, r_len, r_key};
        case (r_state)
            oaht_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr[oaht_pkg::ADDR_W-1:0];
                mem_wdata = '0;
            end
            oaht_pkg::S_WRITE: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (r_state == oaht_pkg::S_READ) begin
            r_rd <= mem[mem_addr];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            oaht_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_opcode == oaht_pkg::OP_CLEAR) begin
                        n_state = oaht_pkg::S_CLEAR;
                    end else if (i_opcode == oaht_pkg::OP_INSERT ||
                                 i_opcode == oaht_pkg::OP_SEARCH) begin
                        n_state = oaht_pkg::S_HASH;
                    end else begin
                        n_state = oaht_pkg::S_DONE;
                    end
                end
            end
            oaht_pkg::S_CLEAR: begin
                if (r_clr == (oaht_pkg::ADDR_W+1)'(oaht_pkg::TABLE_DEPTH - 1)) begin
                    n_state = r_clr_rep ? oaht_pkg::S_DONE : oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_HASH: begin
                if (r_j >= r_len) n_state = oaht_pkg::S_DIV;
            end
            oaht_pkg::S_DIV: begin
                if (div_last) begin
                    if (r_dret == oaht_pkg::DR_HASH &&
                        r_probe_mode == oaht_pkg::PM_DOUBLE) begin
                        n_state = oaht_pkg::S_DIV;
                    end else begin
                        n_state = oaht_pkg::S_READ;
                    end
                end
            end
            oaht_pkg::S_READ:  n_state = oaht_pkg::S_CHECK;
            oaht_pkg::S_CHECK: begin
                if (!walk_stop) begin
                    n_state = oaht_pkg::S_MUL;
                end else if (r_op == oaht_pkg::OP_INSERT && !rd_used) begin
                    n_state = oaht_pkg::S_WRITE;
                end else begin
                    n_state = oaht_pkg::S_DONE;
                end
            end
            oaht_pkg::S_MUL:   n_state = oaht_pkg::S_ADD;
            oaht_pkg::S_ADD:   n_state = oaht_pkg::S_DIV;
            oaht_pkg::S_WRITE: n_state = oaht_pkg::S_DONE;
            oaht_pkg::S_DONE:  n_state = oaht_pkg::S_IDLE;
            default:           n_state = oaht_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy         = (r_state != oaht_pkg::S_IDLE);
        o_done         = (r_state == oaht_pkg::S_DONE);
        o_slot_index   = r_cur;
        o_probe_count  = r_i;
        o_key_found    = r_found;
        o_key_inserted = r_ins;
        o_gave_up      = r_gave;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= oaht_pkg::S_CLEAR;
            r_clr        <= '0;
            r_clr_rep    <= 1'b0;
            r_hash_sel   <= 1'b0;
            r_probe_mode <= oaht_pkg::PM_LINEAR;
            r_dmod       <= oaht_pkg::MOD_W'(10007);
            r_size       <= oaht_pkg::SIZE_W'(38197);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    oaht_pkg::REG_HASH_SEL: r_hash_sel   <= i_cfg_data[0];
                    oaht_pkg::REG_PROBE:    r_probe_mode <= i_cfg_data[1:0];
                    oaht_pkg::REG_DMOD:     r_dmod       <= i_cfg_data[15:0];
                    oaht_pkg::REG_SIZE:     r_size       <= i_cfg_data;
                    default:                r_size       <= r_size;
                endcase
            end
            if (r_state == oaht_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else begin
                r_clr <= '0;
            end
            if (accept) begin
                r_clr_rep <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            oaht_pkg::S_IDLE: begin
                if (accept) begin
                    r_op    <= i_opcode;
                    r_key   <= key_mask;
                    r_len   <= len_sat;
                    r_v     <= (len_sat != '0) ? {24'd0, i_key_bytes[7:0]} : 32'd0;
                    r_j     <= oaht_pkg::LEN_W'(1);
                    r_cur   <= '0;
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_gave  <= 1'b0;
                    r_ins   <= 1'b0;
                end
            end
            oaht_pkg::S_HASH: begin
                if (r_j < r_len) begin
                    r_v <= r_hash_sel ? (r_v << 5) + sbyte : r_v + sbyte;
                    r_j <= r_j + 1'b1;
                end else begin
                    r_dvd  <= r_v;
                    r_dvs  <= tam;
                    r_rem  <= '0;
                    r_dcnt <= 5'd31;
                    r_dret <= oaht_pkg::DR_HASH;
                end
            end
            oaht_pkg::S_DIV: begin
                if (!div_last) begin
                    r_dvd  <= r_dvd << 1;
                    r_rem  <= div_rem;
                    r_dcnt <= r_dcnt - 1'b1;
                end else begin
                    case (r_dret)
                        oaht_pkg::DR_HASH: begin
                            r_x   <= div_rem[oaht_pkg::ADDR_W-1:0];
                            r_cur <= div_rem[oaht_pkg::ADDR_W-1:0];
                            r_dvd <= {16'd0, div_rem[oaht_pkg::ADDR_W-1:0]};
                            r_dvs <= oaht_pkg::SIZE_W'(m_eff);
                            r_rem <= '0;
                            r_dcnt <= 5'd31;
                            r_dret <= oaht_pkg::DR_DMOD;
                        end
                        oaht_pkg::DR_DMOD: begin
                            r_d <= m_eff - div_rem[oaht_pkg::MOD_W-1:0];
                        end
                        default: begin
                            r_cur <= div_rem[oaht_pkg::ADDR_W-1:0];
                        end
                    endcase
                end
            end
            oaht_pkg::S_CHECK: begin
                r_found <= rd_used && rd_eq;
                r_gave  <= rd_used && !rd_eq && at_limit;
                if (!walk_stop) begin
                    r_i <= r_i + 1'b1;
                end
            end
            oaht_pkg::S_MUL: begin
                r_prod <= oaht_pkg::PROD_W'(r_i) * oaht_pkg::PROD_W'(factor);
            end
            oaht_pkg::S_ADD: begin
                r_dvd  <= 32'(r_x) + 32'(r_prod);
                r_dvs  <= tam;
                r_rem  <= '0;
                r_dcnt <= 5'd31;
                r_dret <= oaht_pkg::DR_PROBE;
            end
            oaht_pkg::S_WRITE: begin
                r_ins <= 1'b1;
            end
            default: begin
                r_ins <= r_ins;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // An insert only writes into a slot that was seen free
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == oaht_pkg::S_WRITE |-> !r_found && !r_gave && !rd_used)
        else $error("slot write without a free slot");

    // Probe counter never passes the limit while a lookup runs
    a_probe_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != oaht_pkg::S_IDLE && r_state != oaht_pkg::S_CLEAR)
        |-> r_i <= oaht_pkg::CNT_W'(oaht_pkg::MAX_PROBES))
        else $error("probe count beyond limit");

    // Result flags are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $countones({o_key_found, o_key_inserted, o_gave_up}) <= 1)
        else $error("conflicting result flags");

    // Done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");
`endif

endmodule

FILE: bench/oaht_checker.sv
`timescale 1ns / 1ps
// Checker for the open addressing hash table core: watches the command, result
// and register channels, keeps its own table model and compares every result.
// Depends on oaht_pkg.
module oaht_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic        i_done,
    input  logic [15:0] i_slot_index,
    input  logic [10:0] i_probe_count,
    input  logic        i_key_found,
    input  logic        i_key_inserted,
    input  logic        i_gave_up,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] slot;
        logic [10:0] probes;
        logic        found;
        logic        inserted;
        logic        gave_up;
    } t_lookup;

    // Model of the slot memory
    bit          slot_taken [oaht_pkg::TABLE_DEPTH];
    logic [63:0] slot_key   [oaht_pkg::TABLE_DEPTH];
    logic [3:0]  slot_len   [oaht_pkg::TABLE_DEPTH];

    // Model of the registers
    logic        hash_sel;
    logic [1:0]  probe_sel;
    logic [15:0] dbl_mod;
    logic [16:0] used_size;

    t_lookup lookups_due[$];
    int      err_cnt = 0;

    function automatic void empty_table();
        for (int j = 0; j < oaht_pkg::TABLE_DEPTH; j++) slot_taken[j] = 1'b0;
    endfunction

    // Walk the probe chain for one command and apply an insert or a clear
    function automatic t_lookup run_lookup(logic [1:0] op, logic [63:0] key_in,
                                           logic [3:0] len_in);
        int unsigned n, tam, x, cur, i, v, s, m, off;
        logic [63:0] k;
        t_lookup     r;
        r = '0;
        if (op == oaht_pkg::OP_CLEAR) begin
            empty_table();
            return r;
        end
        if (op != oaht_pkg::OP_INSERT && op != oaht_pkg::OP_SEARCH) return r;

        n = (len_in > oaht_pkg::KEY_BYTES) ? oaht_pkg::KEY_BYTES : len_in;
        k = key_in;
        if (n < 8) k = k & ((64'd1 << (8 * n)) - 64'd1);

        tam = used_size;
        if (tam == 0) tam = 1;
        if (tam > oaht_pkg::TABLE_DEPTH) tam = oaht_pkg::TABLE_DEPTH;

        // Later bytes are sign extended
        v = (n > 0) ? k[7:0] : 0;
        for (int j = 1; j < n; j++) begin
            s = {{24{k[8*j+7]}}, k[8*j +: 8]};
            v = hash_sel ? ((v << 5) + s) : (v + s);
        end
        x   = v % tam;
        cur = x;
        i   = 0;
        while (1) begin
            if (!slot_taken[cur]) break;
            if (slot_len[cur] == n && slot_key[cur] == k) begin
                r.found = 1'b1;
                break;
            end
            if (i >= oaht_pkg::MAX_PROBES) begin
                r.gave_up = 1'b1;
                break;
            end
            i++;
            case (probe_sel)
                oaht_pkg::PM_QUAD:   off = i * i;
                oaht_pkg::PM_DOUBLE: begin
                    m   = (dbl_mod == 0) ? 1 : dbl_mod;
                    off = i * (m - x % m);
                end
                default:   off = i;
            endcase
            cur = (x + off) % tam;
        end

        if (op == oaht_pkg::OP_INSERT && !r.found && !r.gave_up) begin
            slot_taken[cur] = 1'b1;
            slot_key[cur]   = k;
            slot_len[cur]   = n;
            r.inserted      = 1'b1;
        end
        r.slot   = cur[15:0];
        r.probes = i[10:0];
        return r;
    endfunction

    // Channel monitor: register writes, accepted commands, strobed results
    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            hash_sel  <= 1'b0;
            probe_sel <= oaht_pkg::PM_LINEAR;
            dbl_mod   <= 16'd10007;
            used_size <= 17'd38197;
            empty_table();
            lookups_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    oaht_pkg::REG_HASH_SEL: hash_sel  <= i_cfg_data[0];
                    oaht_pkg::REG_PROBE:    probe_sel <= i_cfg_data[1:0];
                    oaht_pkg::REG_DMOD:     dbl_mod   <= i_cfg_data[15:0];
                    oaht_pkg::REG_SIZE:     used_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                lookups_due.push_back(run_lookup(i_opcode, i_key_bytes, i_key_length));
            if (i_done) begin
                if (lookups_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with no transaction pending", $time);
                end else begin
                    want = lookups_due.pop_front();
                    if (i_slot_index !== want.slot) begin
                        err_cnt++;
                        $display("%0t: slot_index exp %0d got %0d",
                                 $time, want.slot, i_slot_index);
                    end
                    if (i_probe_count !== want.probes) begin
                        err_cnt++;
                        $display("%0t: probe_count exp %0d got %0d",
                                 $time, want.probes, i_probe_count);
                    end
                    if (i_key_found !== want.found) begin
                        err_cnt++;
                        $display("%0t: key_found exp %0b got %0b",
                                 $time, want.found, i_key_found);
                    end
                    if (i_key_inserted !== want.inserted) begin
                        err_cnt++;
                        $display("%0t: key_inserted exp %0b got %0b",
                                 $time, want.inserted, i_key_inserted);
                    end
                    if (i_gave_up !== want.gave_up) begin
                        err_cnt++;
                        $display("%0t: gave_up exp %0b got %0b",
                                 $time, want.gave_up, i_gave_up);
                    end
                end
            end
        end
        o_pending <= lookups_due.size();
        o_errors  <= err_cnt;
    end

endmodule

FILE: bench/open_addressing_hash_table_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for open_addressing_hash_table_core: clock, reset, register
// phases and bursty command stimulus; checking lives in oaht_checker.
// Depends on oaht_pkg, oaht_checker and the core.
module open_addressing_hash_table_core_tb;

    localparam logic [1:0] PM_SPARE   = 2'd3;  // unused mode, probes linearly
    localparam logic [1:0] OP_SPARE   = 2'd3;  // unused opcode, gives a result with no flags set
    localparam int         IDLE_LIMIT = 300000;
    localparam int         PHASES     = 5;
    localparam int         PHASE_CMDS = 100;
    localparam int         POOL_N     = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_opcode = oaht_pkg::OP_CLEAR;
    logic [63:0] i_key_bytes = '0;
    logic [3:0]  i_key_length = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = oaht_pkg::REG_HASH_SEL;
    logic [16:0] i_cfg_data = '0;
    logic        o_busy, o_done, o_key_found, o_key_inserted, o_gave_up, o_cfg_ready;
    logic [15:0] o_slot_index;
    logic [10:0] o_probe_count;
    int          fail_cnt, lookups_open;
    int          quiet_cycles = 0;
    int          burst_left = 0;

    logic [63:0] pool_key [POOL_N];
    logic [3:0]  pool_len [POOL_N];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    open_addressing_hash_table_core uut (.*);

    oaht_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_opcode, .i_key_bytes,
        .i_key_length, .i_done(o_done), .i_slot_index(o_slot_index),
        .i_probe_count(o_probe_count), .i_key_found(o_key_found),
        .i_key_inserted(o_key_inserted), .i_gave_up(o_gave_up), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(fail_cnt), .o_pending(lookups_open)
    );

    // Watchdog: long stretches with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // One command transaction; gaps fall between random-length bursts
    task automatic send_cmd(logic [1:0] op, logic [63:0] key, logic [3:0] len);
        i_start      <= 1'b1;
        i_opcode     <= op;
        i_key_bytes  <= key;
        i_key_length <= len;
        do @(posedge i_clk); while (o_busy);
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (o_busy || lookups_open != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic hs, logic [1:0] pm, logic [16:0] dm, logic [16:0] sz);
        write_reg(oaht_pkg::REG_HASH_SEL, {16'd0, hs});
        write_reg(oaht_pkg::REG_PROBE, {15'd0, pm});
        write_reg(oaht_pkg::REG_DMOD, dm);
        write_reg(oaht_pkg::REG_SIZE, sz);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [1:0]  pm_list [PHASES] = '{oaht_pkg::PM_LINEAR, oaht_pkg::PM_QUAD,
                                          oaht_pkg::PM_DOUBLE, oaht_pkg::PM_DOUBLE,
                                          oaht_pkg::PM_LINEAR};
        logic [16:0] dm_list [PHASES] = '{17'd10007, 17'd7, 17'd13, 17'd0, 17'd65535};
        logic [16:0] sz_list [PHASES] = '{17'd61, 17'd127, 17'd97, 17'd53, 17'd131071};
        int          pick, roll;
        logic [63:0] k;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();  // covers the sweep after reset

        // Directed: reset settings, length and byte edge cases
        send_cmd(oaht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_cmd(oaht_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_cmd(oaht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_cmd(oaht_pkg::OP_SEARCH, 64'h1234_5678, 4'd0);
        send_cmd(oaht_pkg::OP_INSERT, 64'hDEAD_BEEF, 4'd0);
        send_cmd(oaht_pkg::OP_SEARCH, 64'd0, 4'd0);
        send_cmd(oaht_pkg::OP_INSERT, 64'h8081_8283_8485_8687, 4'd15);
        send_cmd(oaht_pkg::OP_SEARCH, 64'h8081_8283_8485_8687, 4'd8);
        send_cmd(oaht_pkg::OP_INSERT, 64'hFFFF_FF41, 4'd1);
        send_cmd(oaht_pkg::OP_SEARCH, 64'h41, 4'd1);
        send_cmd(oaht_pkg::OP_SEARCH, 64'h0, 4'd1);
        send_cmd(OP_SPARE, 64'h5555_AAAA_5555_AAAA, 4'd4);
        wait_idle();

        // Zero table size: one slot, so a second key exhausts the probes
        set_regs(1'b1, PM_SPARE, 17'd0, 17'd0);
        send_cmd(oaht_pkg::OP_INSERT, 64'h0102_0304, 4'd4);
        send_cmd(oaht_pkg::OP_SEARCH, 64'h0102_0304, 4'd4);
        send_cmd(oaht_pkg::OP_INSERT, 64'h7F80_FF00, 4'd4);
        send_cmd(oaht_pkg::OP_SEARCH, 64'h7F80_FF00, 4'd4);
        wait_idle();

        // Oversized table, widest modulus, then a clear
        set_regs(1'b1, oaht_pkg::PM_DOUBLE, 17'd65535, 17'h1FFFF);
        send_cmd(oaht_pkg::OP_INSERT, 64'hFEDC_BA98_7654_3210, 4'd8);
        send_cmd(oaht_pkg::OP_INSERT, 64'h0123_4567_89AB_CDEF, 4'd7);
        send_cmd(oaht_pkg::OP_SEARCH, 64'hFEDC_BA98_7654_3210, 4'd8);
        send_cmd(oaht_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_cmd(oaht_pkg::OP_SEARCH, 64'hFEDC_BA98_7654_3210, 4'd8);
        wait_idle();

        // Random phases: a small pool of keys so inserts collide and searches hit
        for (int p = 0; p < PHASES; p++) begin
            set_regs(p[0], pm_list[p], dm_list[p], sz_list[p]);
            for (int j = 0; j < POOL_N; j++) begin
                pool_key[j] = rand_key();
                pool_len[j] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 8);
            end
            send_cmd(oaht_pkg::OP_CLEAR, rand_key(), $urandom_range(0, 15));
            for (int n = 0; n < PHASE_CMDS; n++) begin
                pick = $urandom_range(0, POOL_N - 1);
                roll = $urandom_range(0, 99);
                // reuse the pool key with fresh garbage past its length
                k = rand_key();
                for (int b = 0; b < 8; b++)
                    if (b < pool_len[pick]) k[8*b +: 8] = pool_key[pick][8*b +: 8];
                if (roll < 45)
                    send_cmd(oaht_pkg::OP_INSERT, k, pool_len[pick]);
                else if (roll < 85)
                    send_cmd(oaht_pkg::OP_SEARCH, k, pool_len[pick]);
                else if (roll < 95)
                    send_cmd(oaht_pkg::OP_SEARCH, rand_key(), $urandom_range(0, 15));
                else if (roll < 99)
                    send_cmd(OP_SPARE, rand_key(), $urandom_range(0, 15));
                else
                    send_cmd(oaht_pkg::OP_CLEAR, rand_key(), $urandom_range(0, 15));
            end
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
